/* sv/jsu_pkg.sv */
// shared types and constants of the json string unescape unit
package jsu_pkg;

  // length limit: the smaller of the design maximum and the 16-bit field
  localparam logic [31:0] MAX_LENGTH = 32'd65535;
  localparam logic [15:0] LEN_LIMIT  = (MAX_LENGTH < 32'd65535) ? MAX_LENGTH[15:0] : 16'hffff;

  // most data bytes one input byte can release (a six-byte raw sequence)
  localparam int GROUP_BYTES = 6;
  localparam int GROUP_CNT_W = $clog2(GROUP_BYTES + 1);

  // capacity reset value
  localparam logic [15:0] CAPACITY_RESET = 16'hffff;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_data;
    logic        is_last;
    logic        decode_error;
    logic [15:0] needed_length;
  } out_word_t;

  // everything one input byte releases: data bytes and an optional status word
  typedef struct packed {
    logic [GROUP_BYTES-1:0][7:0] bytes;
    logic [GROUP_CNT_W-1:0]      count;
    logic                        stat;
    logic                        stat_err;
    logic [15:0]                 stat_len;
  } group_t;

endpackage

/* sv/jsu_decode.sv */
// per-byte decode state and the step logic that builds one output group
module jsu_decode (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  jsu_pkg::in_word_t in_word,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_data,
  output jsu_pkg::group_t  grp
);

  typedef enum logic [6:0] {
    MODE_PLAIN  = 7'b0000001,
    MODE_ESC    = 7'b0000010,
    MODE_HEX    = 7'b0000100,
    MODE_SUR_BS = 7'b0001000,
    MODE_SUR_U  = 7'b0010000,
    MODE_UTF8   = 7'b0100000,
    MODE_ERR    = 7'b1000000
  } mode_t;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CTL_BS    = 8'h08;
  localparam logic [7:0] CTL_TAB   = 8'h09;
  localparam logic [7:0] CTL_LF    = 8'h0a;
  localparam logic [7:0] CTL_FF    = 8'h0c;
  localparam logic [7:0] CTL_CR    = 8'h0d;
  localparam logic [15:0] SUR_HI_LO = 16'hd800;
  localparam logic [15:0] SUR_HI_HI = 16'hdbff;
  localparam logic [15:0] SUR_LO_LO = 16'hdc00;
  localparam logic [15:0] SUR_LO_HI = 16'hdfff;
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [7:0] CONT_MARK = 8'h80;
  localparam logic [7:0] LEAD2     = 8'hc0;
  localparam logic [7:0] LEAD3     = 8'he0;
  localparam logic [7:0] LEAD4     = 8'hf0;

  localparam int CW = jsu_pkg::GROUP_CNT_W;

  // hex digit value, bit 4 flags a non-hex byte
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    if (b >= 8'h30 && b <= 8'h39) v = {1'b0, b[3:0]};
    else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
      v = {1'b0, b[3:0] + 4'd9};
    else v = 5'h10;
    return v;
  endfunction

  // utf-8 sequence length from the lead byte, zero for a bad lead
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] n;
    if (b[7] == 1'b0) n = 3'd1;
    else if (b[7:5] == 3'b110) n = 3'd2;
    else if (b[7:4] == 4'b1110) n = 3'd3;
    else if (b[7:3] == 5'b11110) n = 3'd4;
    else if (b[7:2] == 6'b111110) n = 3'd5;
    else if (b[7:1] == 7'b1111110) n = 3'd6;
    else n = 3'd0;
    return n;
  endfunction

  // state registers
  mode_t       mode, mode_next;
  logic [2:0]  hex_cnt, hex_cnt_next;
  logic [15:0] acc, acc_next;
  logic [15:0] pend, pend_next;
  logic [4:0][7:0] hold, hold_next;
  logic [2:0]  expect_cnt, expect_cnt_next;
  logic [15:0] cap_left, cap_left_next;
  logic [15:0] len, len_next;
  logic        err, err_next;
  logic [15:0] capacity;

  // step logic
  logic [7:0]  b;
  logic [CW-1:0] g_n;
  logic [jsu_pkg::GROUP_BYTES-1:0][7:0] g_bytes;
  logic        fail_f;
  logic [4:0]  hv;
  logic [15:0] acc_new;
  logic [15:0] code;
  logic [20:0] supp;
  logic [2:0]  ln;
  logic [2:0]  pos;
  logic        fits;
  logic [16:0] len_sum;

  always_comb begin
    b               = in_word.in_byte;
    mode_next       = mode;
    hex_cnt_next    = hex_cnt;
    acc_next        = acc;
    pend_next       = pend;
    hold_next       = hold;
    expect_cnt_next = expect_cnt;
    g_n             = '0;
    g_bytes         = '0;
    fail_f          = 1'b0;
    hv              = hex_value(b);
    acc_new         = {acc[11:0], hv[3:0]};
    code            = acc_new;
    supp            = {1'b0, pend[9:0], acc_new[9:0]} + SUPP_BASE;
    ln              = lead_length(hold[0]);
    pos             = ln - expect_cnt;
    grp             = '0;

    case (mode)
      MODE_PLAIN: begin
        if (b == CH_BSLASH) begin
          mode_next = MODE_ESC;
        end else if (lead_length(b) == 3'd1) begin
          g_bytes[0] = b;
          g_n        = CW'(1);
        end else if (lead_length(b) == 3'd0) begin
          fail_f = 1'b1;
        end else begin
          hold_next[0]    = b;
          expect_cnt_next = lead_length(b) - 3'd1;
          mode_next       = MODE_UTF8;
        end
      end
      MODE_ESC: begin
        mode_next = MODE_PLAIN;
        g_n       = CW'(1);
        case (b)
          CH_B: g_bytes[0] = CTL_BS;
          CH_T: g_bytes[0] = CTL_TAB;
          CH_N: g_bytes[0] = CTL_LF;
          CH_F: g_bytes[0] = CTL_FF;
          CH_R: g_bytes[0] = CTL_CR;
          CH_U: begin
            mode_next    = MODE_HEX;
            hex_cnt_next = 3'd0;
            acc_next     = '0;
            g_n          = '0;
          end
          default: g_bytes[0] = b;
        endcase
      end
      MODE_HEX: begin
        if (hv[4]) begin
          fail_f = 1'b1;
        end else if (hex_cnt != 3'd3) begin
          acc_next     = acc_new;
          hex_cnt_next = hex_cnt + 3'd1;
        end else begin
          // fourth digit: resolve the code unit
          hex_cnt_next = 3'd0;
          acc_next     = '0;
          if (code >= SUR_HI_LO && code <= SUR_HI_HI) begin
            if (pend != '0) begin
              fail_f = 1'b1;
            end else begin
              pend_next = code;
              mode_next = MODE_SUR_BS;
            end
          end else if (code >= SUR_LO_LO && code <= SUR_LO_HI) begin
            if (pend == '0) begin
              fail_f = 1'b1;
            end else begin
              pend_next  = '0;
              mode_next  = MODE_PLAIN;
              g_bytes[0] = LEAD4 | {5'b0, supp[20:18]};
              g_bytes[1] = CONT_MARK | {2'b0, supp[17:12]};
              g_bytes[2] = CONT_MARK | {2'b0, supp[11:6]};
              g_bytes[3] = CONT_MARK | {2'b0, supp[5:0]};
              g_n        = CW'(4);
            end
          end else if (pend != '0) begin
            fail_f = 1'b1;
          end else begin
            mode_next = MODE_PLAIN;
            if (code <= 16'h007f) begin
              g_bytes[0] = code[7:0];
              g_n        = CW'(1);
            end else if (code <= 16'h07ff) begin
              g_bytes[0] = LEAD2 | {3'b0, code[10:6]};
              g_bytes[1] = CONT_MARK | {2'b0, code[5:0]};
              g_n        = CW'(2);
            end else begin
              g_bytes[0] = LEAD3 | {4'b0, code[15:12]};
              g_bytes[1] = CONT_MARK | {2'b0, code[11:6]};
              g_bytes[2] = CONT_MARK | {2'b0, code[5:0]};
              g_n        = CW'(3);
            end
          end
        end
      end
      MODE_SUR_BS: begin
        if (b == CH_BSLASH) mode_next = MODE_SUR_U;
        else fail_f = 1'b1;
      end
      MODE_SUR_U: begin
        if (b == CH_U) begin
          mode_next    = MODE_HEX;
          hex_cnt_next = 3'd0;
          acc_next     = '0;
        end else begin
          fail_f = 1'b1;
        end
      end
      MODE_UTF8: begin
        if (b[7:6] != 2'b10 || expect_cnt == 3'd0) begin
          fail_f = 1'b1;
        end else if (ln < 3'd2 || ln > 3'd6 || expect_cnt > ln - 3'd1) begin
          fail_f = 1'b1;
        end else begin
          expect_cnt_next = expect_cnt - 3'd1;
          if (expect_cnt == 3'd1) begin
            // sequence complete: held bytes then this one
            for (int j = 0; j < jsu_pkg::GROUP_BYTES; j++) begin
              if (j < 5 && 3'(j) < ln - 3'd1) g_bytes[j] = hold[j];
              else if (3'(j) == ln - 3'd1) g_bytes[j] = b;
            end
            g_n       = CW'(ln);
            mode_next = MODE_PLAIN;
          end else begin
            for (int k = 0; k < 5; k++) begin
              if (3'(k) == pos) hold_next[k] = b;
            end
          end
        end
      end
      MODE_ERR: mode_next = MODE_ERR;
      default:  mode_next = MODE_ERR;
    endcase

    // bad byte: swallow the rest of the string
    err_next = err;
    if (fail_f) begin
      err_next        = 1'b1;
      mode_next       = MODE_ERR;
      hex_cnt_next    = 3'd0;
      acc_next        = '0;
      pend_next       = '0;
      expect_cnt_next = 3'd0;
    end

    // capacity check and saturating length count
    fits          = {{(16-CW){1'b0}}, g_n} <= cap_left;
    cap_left_next = fits ? cap_left - {{(16-CW){1'b0}}, g_n} : cap_left;
    len_sum       = {1'b0, len} + {{(17-CW){1'b0}}, g_n};
    len_next      = (len_sum > {1'b0, jsu_pkg::LEN_LIMIT}) ? jsu_pkg::LEN_LIMIT
                                                          : len_sum[15:0];
    grp.bytes     = g_bytes;
    grp.count     = fits ? g_n : '0;

    // end of string: status word, then clear the string state
    if (in_word.in_last) begin
      grp.stat        = 1'b1;
      grp.stat_err    = err_next | (mode_next != MODE_PLAIN);
      grp.stat_len    = len_next;
      mode_next       = MODE_PLAIN;
      hex_cnt_next    = 3'd0;
      acc_next        = '0;
      pend_next       = '0;
      expect_cnt_next = 3'd0;
      cap_left_next   = capacity;
      len_next        = '0;
      err_next        = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_PLAIN;
      hex_cnt    <= '0;
      acc        <= '0;
      pend       <= '0;
      expect_cnt <= '0;
      cap_left   <= jsu_pkg::CAPACITY_RESET;
      len        <= '0;
      err        <= 1'b0;
      capacity   <= jsu_pkg::CAPACITY_RESET;
    end else begin
      if (step) begin
        mode       <= mode_next;
        hex_cnt    <= hex_cnt_next;
        acc        <= acc_next;
        pend       <= pend_next;
        expect_cnt <= expect_cnt_next;
        cap_left   <= cap_left_next;
        len        <= len_next;
        err        <= err_next;
      end
      if (cfg_we) begin
        capacity <= cfg_data;
        if (mode == MODE_PLAIN && len == '0 && !err) cap_left <= cfg_data;
      end
    end
  end

  // held raw sequence bytes
  always_ff @(posedge clk) begin
    if (step) hold <= hold_next;
  end

endmodule

/* sv/jsu_emit.sv */
// group register that hands out data words and the status word one at a time
module jsu_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  jsu_pkg::group_t    grp,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output jsu_pkg::out_word_t out_word
);

  localparam int CW = jsu_pkg::GROUP_CNT_W;

  logic [jsu_pkg::GROUP_BYTES-1:0][7:0] bytes;
  logic [CW-1:0] data_left;
  logic [CW-1:0] data_idx;
  logic          stat_pend;
  logic          stat_err;
  logic [15:0]   stat_len;
  logic          final_word;

  assign out_valid  = (data_left != '0) || stat_pend;
  assign final_word = (data_left == CW'(1) && !stat_pend) || (data_left == '0 && stat_pend);
  assign can_load   = !out_valid || (out_ready && final_word);

  // current word
  always_comb begin
    out_word = '0;
    if (data_left != '0) begin
      out_word.out_byte = bytes[data_idx];
      out_word.is_data  = 1'b1;
    end else begin
      out_word.is_last       = 1'b1;
      out_word.decode_error  = stat_err;
      out_word.needed_length = stat_len;
    end
  end

  // word counters
  always_ff @(posedge clk) begin
    if (rst) begin
      data_left <= '0;
      data_idx  <= '0;
      stat_pend <= 1'b0;
    end else if (load) begin
      data_left <= grp.count;
      data_idx  <= '0;
      stat_pend <= grp.stat;
    end else if (out_valid && out_ready) begin
      if (data_left != '0) begin
        data_left <= data_left - CW'(1);
        data_idx  <= data_idx + CW'(1);
      end else begin
        stat_pend <= 1'b0;
      end
    end
  end

  // group payload
  always_ff @(posedge clk) begin
    if (load) begin
      bytes    <= grp.bytes;
      stat_err <= grp.stat_err;
      stat_len <= grp.stat_len;
    end
  end

endmodule

/* sv/json_string_unescape_utf8_unit.sv */
// top level of the json string unescape unit with utf-8 output
// the first word of an item is offered once it has passed the input register and the group register
// throughput: one item per cycle while each item gives at most one word and out_ready
//   is held high; an item that releases more than one word (up to seven) holds the input
//   until the single-word output register has drained its group
// reset: synchronous, capacity returns to 65535, no clearing pass
module json_string_unescape_utf8_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  jsu_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output jsu_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  logic              in_full;
  jsu_pkg::in_word_t in_hold;
  logic              can_load;
  logic              step;
  jsu_pkg::group_t   grp;

  assign step      = in_full && can_load;
  assign in_ready  = !in_full || step;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_hold <= in_word;
  end

  jsu_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .in_word  (in_hold),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .grp      (grp)
  );

  jsu_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .grp       (grp),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
